// ----- src/grc_pkg.sv -----
// grc_pkg: shared constants, payload structs and controller/datapath link types
// for the grid ray caster. no dependencies.
package grc_pkg;

    localparam int MAP_DIM   = 32;
    localparam int MAP_CELLS = 1024;
    localparam int TEX_SIZE  = 64;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CAST = 1'b1;

    // register indexes, byte address is 4 times the index
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LINE_SCALE = 2'd2;
    localparam logic [1:0] REG_MIN_HEIGHT = 2'd3;

    localparam logic [5:0]  MAP_WIDTH_RST  = 6'd32;
    localparam logic [5:0]  MAP_HEIGHT_RST = 6'd32;
    localparam logic [15:0] LINE_SCALE_RST = 16'd272;
    localparam logic [11:0] MIN_HEIGHT_RST = 12'd0;

    localparam logic [11:0] HEIGHT_MAX = 12'd4095;

    typedef struct packed {
        logic               mode;
        logic        [9:0]  cell_index;
        logic        [7:0]  cell_value;
        logic        [14:0] origin_x;
        logic        [14:0] origin_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic        [15:0] fisheye_factor;
    } item_t;

    typedef struct packed {
        logic        hit_found;
        logic [4:0]  hit_cell_x;
        logic [4:0]  hit_cell_y;
        logic [7:0]  wall_id;
        logic        hit_side;
        logic [15:0] ray_length;
        logic [5:0]  texture_column;
        logic [11:0] line_height;
    } result_t;

    typedef enum logic [1:0] {
        DIV_LEN,
        DIV_OFF,
        DIV_HGT
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     init;
        logic     read;
        logic     set_hit;
        logic     eval;
        logic     step;
        logic     fin;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_len;
        logic     store_off;
        logic     store_h;
    } cmd_t;

    typedef struct packed {
        logic stop_walk;
        logic cell_nz;
        logic dir_zero;
        logic crossed;
        logic div_done;
        logic len_zero;
    } stat_t;

endpackage

// ----- src/grid_ray_caster.sv -----
// grid_ray_caster: top level - configuration registers, sequencer and datapath.
// depends on grc_pkg, grc_ctrl, grc_dp.
//
// usage:
//   a word on item is taken at a rising edge with start high and busy low.
//   mode load writes one map cell in that edge, gives no result and keeps
//   busy low, so loads may follow each other every cycle.
//   mode cast raises busy and walks the ray: each grid step is a map read,
//   the distance products and a compare, for at most map_width*map_height
//   steps. it then runs up to three divisions (length, hit offset, line
//   height) on one shared bit-serial divider.
//   the result word stands on result with result_valid high for exactly one
//   cycle; the receiver cannot hold it off. busy falls the cycle after.
//   the apb port reads and writes map_width, map_height, line_scale and
//   min_height at byte addresses 0, 4, 8 and 12; write only while idle.
//   reset clears the registers to their defaults and returns to idle; map
//   cells hold nothing defined until loaded.
module grid_ray_caster #(
    parameter int MAP_DIM   = grc_pkg::MAP_DIM,
    parameter int MAP_CELLS = grc_pkg::MAP_CELLS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  grc_pkg::item_t   item,
    output logic             result_valid,
    output grc_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [5:0]     map_width_reg, map_height_reg;
    logic [15:0]    line_scale_reg;
    logic [11:0]    min_height_reg;
    logic           cfg_we;
    grc_pkg::cmd_t  cmd;
    grc_pkg::stat_t stat;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= grc_pkg::MAP_WIDTH_RST;
            map_height_reg <= grc_pkg::MAP_HEIGHT_RST;
            line_scale_reg <= grc_pkg::LINE_SCALE_RST;
            min_height_reg <= grc_pkg::MIN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                grc_pkg::REG_MAP_WIDTH:  map_width_reg  <= pwdata[5:0];
                grc_pkg::REG_MAP_HEIGHT: map_height_reg <= pwdata[5:0];
                grc_pkg::REG_LINE_SCALE: line_scale_reg <= pwdata[15:0];
                grc_pkg::REG_MIN_HEIGHT: min_height_reg <= pwdata[11:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            grc_pkg::REG_MAP_WIDTH:  prdata = 32'(map_width_reg);
            grc_pkg::REG_MAP_HEIGHT: prdata = 32'(map_height_reg);
            grc_pkg::REG_LINE_SCALE: prdata = 32'(line_scale_reg);
            grc_pkg::REG_MIN_HEIGHT: prdata = 32'(min_height_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    grc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (item.mode),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .result_valid(result_valid)
    );

    grc_dp #(
        .MAP_DIM  (MAP_DIM),
        .MAP_CELLS(MAP_CELLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .map_width (map_width_reg),
        .map_height(map_height_reg),
        .line_scale(line_scale_reg),
        .min_height(min_height_reg),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    // result strobe lasts one cycle and is followed by idle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid && !busy)
        else $error("result strobe longer than one cycle");

    // a load word never makes the block busy
    a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == grc_pkg::MODE_LOAD) |=> !busy)
        else $error("load word raised busy");

    // results only come out of a cast in progress
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result without a cast");

    // a ray that found no wall reports wall id zero
    a_miss_wall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.hit_found || result.wall_id == 8'd0))
        else $error("wall id on a miss");

endmodule

// ----- src/grc_ram.sv -----
// grc_ram: generic single write port, single read port ram with registered read.
// no dependencies.
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/grc_div.sv -----
// grc_div: restoring unsigned divider, one quotient bit per cycle.
// no dependencies.
module grc_div #(
    parameter int W = 34
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic [W:0]      rem_reg;
    logic [W-1:0]    quo_reg;
    logic [W-1:0]    dsr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [W:0]      shifted;
    logic [W:0]      trial;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            if (trial[W])
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/grc_dp.sv -----
// grc_dp: ray caster datapath - map ram, walk registers, step compare and the
// shared divider. depends on grc_pkg, grc_ram, grc_div.
module grc_dp #(
    parameter int MAP_DIM   = grc_pkg::MAP_DIM,
    parameter int MAP_CELLS = grc_pkg::MAP_CELLS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  grc_pkg::item_t   item,
    input  logic [5:0]       map_width,
    input  logic [5:0]       map_height,
    input  logic [15:0]      line_scale,
    input  logic [11:0]      min_height,
    input  grc_pkg::cmd_t    cmd,
    output grc_pkg::stat_t   stat,
    output grc_pkg::result_t result
);

    localparam int CW   = ($clog2(MAP_DIM) + 2 > 7) ? $clog2(MAP_DIM) + 2 : 7;
    localparam int DW   = $clog2(MAP_DIM + 1);
    localparam int SW   = 2 * DW;
    localparam int DVW  = ($clog2(MAP_DIM) + 11 > 15) ? $clog2(MAP_DIM) + 11 : 15;
    localparam int PW   = DVW + 16;
    localparam int LW   = DVW + 14;
    localparam int DIVW = LW + 4;
    localparam int AW   = $clog2(MAP_CELLS);
    localparam int AFW  = (SW + 1 > AW) ? SW + 1 : AW;

    function automatic logic [DW-1:0] clamp_dim(input logic [5:0] v);
        logic [DW-1:0] r;
        if (v == 6'd0)
        begin
            r = DW'(1);
        end
        else if (32'(v) > MAP_DIM)
        begin
            r = DW'(MAP_DIM);
        end
        else
        begin
            r = DW'(v);
        end
        return r;
    endfunction

    logic [DW-1:0]        w_reg, h_reg;
    logic [SW-1:0]        limit_reg, step_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [14:0]          ox_reg, oy_reg;
    logic                 dx_neg_reg, dy_neg_reg, dx_zero_reg, dy_zero_reg;
    logic [15:0]          adx_reg, ady_reg;
    logic [31:0]          num_reg;
    logic [DVW-1:0]       dvx_reg, dvy_reg, dv_last_reg;
    logic [PW-1:0]        prod_a_reg, prod_b_reg, prod_off_reg;
    logic [LW-1:0]        len_reg;
    logic [9:0]           frac_reg;
    logic                 hit_reg, side_reg, crossed_reg, oob_reg;
    logic [7:0]           wid_reg;
    logic [11:0]          hgt_reg;

    logic [AFW-1:0]  addr_full;
    logic            ram_we;
    logic [7:0]      rdata;
    logic [DVW-1:0]  cxu, cyu, oxw, oyw, dvx, dvy;
    logic            vert;
    logic [15:0]     ad_div;
    logic [DIVW-1:0] div_a, div_b, quo;
    logic            div_done;
    logic [11:0]     hgt_sat;
    logic            flip;
    logic [10:0]     tex_base;
    logic [19:0]     tex_prod;
    logic [9:0]      tex_raw;
    logic [9:0]      tex_cl;

    // map writes come straight from load words
    assign ram_we = cmd.load && (32'(item.cell_index) < MAP_CELLS);

    assign addr_full = AFW'(unsigned'(cy_reg)) * AFW'(w_reg) + AFW'(unsigned'(cx_reg));

    grc_ram #(
        .WIDTH(8),
        .DEPTH(MAP_CELLS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(item.cell_index)),
        .wdata(item.cell_value),
        .raddr(addr_full[AW-1:0]),
        .rdata(rdata)
    );

    // distances to the next grid lines, cell is known to lie inside the map
    assign cxu = DVW'(unsigned'(cx_reg));
    assign cyu = DVW'(unsigned'(cy_reg));
    assign oxw = DVW'(ox_reg);
    assign oyw = DVW'(oy_reg);
    assign dvx = dx_neg_reg ? (oxw - (cxu << 10)) : (((cxu + DVW'(1)) << 10) - oxw);
    assign dvy = dy_neg_reg ? (oyw - (cyu << 10)) : (((cyu + DVW'(1)) << 10) - oyw);

    // tie goes to the horizontal line
    assign vert = dx_zero_reg ? 1'b0 : (dy_zero_reg ? 1'b1 : (prod_a_reg < prod_b_reg));

    assign ad_div = side_reg ? adx_reg : ady_reg;

    always_comb
    begin
        case (cmd.div_sel)
            grc_pkg::DIV_LEN:
            begin
                div_a = DIVW'({dv_last_reg, 14'd0});
                div_b = DIVW'(ad_div);
            end
            grc_pkg::DIV_OFF:
            begin
                div_a = DIVW'(prod_off_reg);
                div_b = DIVW'(ad_div);
            end
            grc_pkg::DIV_HGT:
            begin
                div_a = DIVW'(num_reg);
                div_b = DIVW'({len_reg, 4'd0});
            end
            default:
            begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    grc_div #(
        .W(DIVW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(div_a),
        .divisor (div_b),
        .done    (div_done),
        .quotient(quo)
    );

    assign hgt_sat = (len_reg == '0) ? grc_pkg::HEIGHT_MAX
                   : ((quo > DIVW'(grc_pkg::HEIGHT_MAX)) ? grc_pkg::HEIGHT_MAX : quo[11:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            w_reg       <= clamp_dim(map_width);
            h_reg       <= clamp_dim(map_height);
            limit_reg   <= SW'(clamp_dim(map_width)) * SW'(clamp_dim(map_height));
            step_reg    <= '0;
            cx_reg      <= CW'(item.origin_x[14:10]);
            cy_reg      <= CW'(item.origin_y[14:10]);
            ox_reg      <= item.origin_x;
            oy_reg      <= item.origin_y;
            dx_neg_reg  <= item.dir_x[15];
            dy_neg_reg  <= item.dir_y[15];
            dx_zero_reg <= (item.dir_x == 16'sd0);
            dy_zero_reg <= (item.dir_y == 16'sd0);
            adx_reg     <= item.dir_x[15] ? 16'(-item.dir_x) : 16'(item.dir_x);
            ady_reg     <= item.dir_y[15] ? 16'(-item.dir_y) : 16'(item.dir_y);
            num_reg     <= 32'(line_scale) * 32'(item.fisheye_factor);
            len_reg     <= '0;
            frac_reg    <= item.origin_x[9:0];
            hit_reg     <= 1'b0;
            wid_reg     <= 8'd0;
            side_reg    <= 1'b0;
            crossed_reg <= 1'b0;
        end
        if (cmd.read)
        begin
            oob_reg <= (32'(addr_full) >= MAP_CELLS);
        end
        if (cmd.set_hit)
        begin
            hit_reg <= 1'b1;
            wid_reg <= rdata;
        end
        if (cmd.eval)
        begin
            dvx_reg    <= dvx;
            dvy_reg    <= dvy;
            prod_a_reg <= PW'(dvx) * PW'(ady_reg);
            prod_b_reg <= PW'(dvy) * PW'(adx_reg);
        end
        if (cmd.step)
        begin
            step_reg    <= step_reg + SW'(1);
            crossed_reg <= 1'b1;
            if (vert)
            begin
                cx_reg      <= dx_neg_reg ? cx_reg - CW'(1) : cx_reg + CW'(1);
                dv_last_reg <= dvx_reg;
                side_reg    <= 1'b1;
            end
            else
            begin
                cy_reg      <= dy_neg_reg ? cy_reg - CW'(1) : cy_reg + CW'(1);
                dv_last_reg <= dvy_reg;
                side_reg    <= 1'b0;
            end
        end
        if (cmd.fin)
        begin
            prod_off_reg <= PW'(side_reg ? ady_reg : adx_reg) * PW'(dv_last_reg);
        end
        if (cmd.store_len)
        begin
            len_reg <= quo[LW-1:0];
        end
        if (cmd.store_off)
        begin
            // only the low ten bits of the hit coordinate matter
            if (side_reg)
            begin
                frac_reg <= dy_neg_reg ? oy_reg[9:0] - quo[9:0] : oy_reg[9:0] + quo[9:0];
            end
            else
            begin
                frac_reg <= dx_neg_reg ? ox_reg[9:0] - quo[9:0] : ox_reg[9:0] + quo[9:0];
            end
        end
        if (cmd.store_h)
        begin
            hgt_reg <= (hgt_sat < min_height) ? 12'd0 : hgt_sat;
        end
    end

    assign stat.stop_walk = (step_reg >= limit_reg) || (cx_reg < 0) || (cy_reg < 0)
                          || (cx_reg >= $signed(CW'(w_reg))) || (cy_reg >= $signed(CW'(h_reg)));
    assign stat.cell_nz   = !oob_reg && (rdata != 8'd0);
    assign stat.dir_zero  = dx_zero_reg && dy_zero_reg;
    assign stat.crossed   = crossed_reg;
    assign stat.div_done  = div_done;
    assign stat.len_zero  = (len_reg == '0);

    // texture column from the fractional hit position
    assign flip     = side_reg ? (!dx_neg_reg && !dx_zero_reg) : dy_neg_reg;
    assign tex_base = flip ? {1'b0, frac_reg} : (11'd1024 - {1'b0, frac_reg});
    assign tex_prod = 20'(tex_base) * 20'(grc_pkg::TEX_SIZE);
    assign tex_raw  = tex_prod[19:10];
    assign tex_cl   = (32'(tex_raw) > grc_pkg::TEX_SIZE - 1) ? 10'(grc_pkg::TEX_SIZE - 1) : tex_raw;

    assign result.hit_found      = hit_reg;
    assign result.hit_cell_x     = cx_reg[4:0];
    assign result.hit_cell_y     = cy_reg[4:0];
    assign result.wall_id        = wid_reg;
    assign result.hit_side       = side_reg;
    assign result.ray_length     = (len_reg > LW'(16'hFFFF)) ? 16'hFFFF : len_reg[15:0];
    assign result.texture_column = tex_cl[5:0];
    assign result.line_height    = hgt_reg;

endmodule

// ----- src/grc_ctrl.sv -----
// grc_ctrl: ray caster sequencer - walks the grid, then runs up to three divisions.
// depends on grc_pkg.
module grc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           mode,
    input  grc_pkg::stat_t stat,
    output grc_pkg::cmd_t  cmd,
    output logic           busy,
    output logic           result_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EVAL,
        S_STEP,
        S_FIN,
        S_DIVLEN,
        S_DIVOFF,
        S_HGT,
        S_DIVH,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && mode == grc_pkg::MODE_LOAD)
                begin
                    cmd.load = 1'b1;
                end
                else if (start)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.stop_walk)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (stat.cell_nz)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_FIN;
                end
                else if (stat.dir_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_CHECK;
            end
            S_FIN:
            begin
                if (stat.crossed)
                begin
                    cmd.fin       = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = grc_pkg::DIV_LEN;
                    state_next    = S_DIVLEN;
                end
                else
                begin
                    state_next = S_HGT;
                end
            end
            S_DIVLEN:
            begin
                cmd.div_sel = grc_pkg::DIV_LEN;
                if (stat.div_done)
                begin
                    cmd.store_len = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = grc_pkg::DIV_OFF;
                    state_next    = S_DIVOFF;
                end
            end
            S_DIVOFF:
            begin
                cmd.div_sel = grc_pkg::DIV_OFF;
                if (stat.div_done)
                begin
                    cmd.store_off = 1'b1;
                    state_next    = S_HGT;
                end
            end
            S_HGT:
            begin
                if (stat.len_zero)
                begin
                    cmd.store_h = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = grc_pkg::DIV_HGT;
                    state_next    = S_DIVH;
                end
            end
            S_DIVH:
            begin
                cmd.div_sel = grc_pkg::DIV_HGT;
                if (stat.div_done)
                begin
                    cmd.store_h = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            valid_reg <= (state_next == S_OUT);
        end
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;

endmodule
